// ----- rtl/bwcc_pkg.sv -----
// Package with the opcodes, constants, control type and CRC helpers of the boot image cipher.
`default_nettype none
package bwcc_pkg;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_ENCODE  = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  localparam logic CFG_SEED_BYTE   = 1'b0;
  localparam logic CFG_CLIENT_BYTE = 1'b1;

  localparam logic [15:0] CRC_POLY     = 16'hA517;
  localparam logic [15:0] CRC_INIT     = 16'hFFF8;
  localparam logic [31:0] SEED_INIT    = 32'hFFFF00C1;
  localparam logic [31:0] SEED_MULT    = 32'h6F646573;
  localparam logic [31:0] ADDR_KEY     = 32'h6465646F;
  localparam logic [31:0] LOAD_BASE    = 32'h02000000;
  localparam logic [15:0] TRAILER_HIGH = 16'hFFFF;
  localparam logic [7:0]  SEED_BIAS    = 8'h0F;

  typedef logic [15:0][15:0] crc_state_cols_t;
  typedef logic [31:0][15:0] crc_word_cols_t;

  typedef struct packed {
    logic fire;
    logic restart;
    logic encode;
    logic finish;
  } ctl_t;

  // Bit-serial fold, used only to build the constant matrices below.
  function automatic logic [15:0] crc_fold_serial(logic [15:0] crc_in, logic [31:0] word_in);
    logic [15:0] crc;
    logic [31:0] word;
    logic        hit;
    crc  = crc_in;
    word = word_in;
    for (int i = 0; i < 32; i++) begin
      hit  = crc[0] ^ word[0];
      crc  = crc >> 1;
      word = word >> 1;
      if (hit) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic crc_state_cols_t build_state_cols();
    crc_state_cols_t cols;
    for (int k = 0; k < 16; k++) begin
      cols[k] = crc_fold_serial(16'(1) << k, 32'd0);
    end
    return cols;
  endfunction

  function automatic crc_word_cols_t build_word_cols();
    crc_word_cols_t cols;
    for (int k = 0; k < 32; k++) begin
      cols[k] = crc_fold_serial(16'd0, 32'(1) << k);
    end
    return cols;
  endfunction

  localparam crc_state_cols_t CRC_STATE_COLS = build_state_cols();
  localparam crc_word_cols_t  CRC_WORD_COLS  = build_word_cols();

  // The fold is linear, so the new CRC is an XOR of constant columns.
  function automatic logic [15:0] crc_fold32(logic [15:0] crc, logic [31:0] word);
    logic [15:0] acc;
    acc = '0;
    for (int k = 0; k < 16; k++) begin
      if (crc[k]) begin
        acc = acc ^ CRC_STATE_COLS[k];
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (word[k]) begin
        acc = acc ^ CRC_WORD_COLS[k];
      end
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bwcc_if.sv -----
// Valid/ready channel interfaces for the input beats and the result beats.
`default_nettype none
interface bwcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] data_word;
  logic [17:0] byte_offset;

  modport source (output valid, output opcode, output data_word, output byte_offset,
                  input ready);
  modport sink (input valid, input opcode, input data_word, input byte_offset,
                output ready);
endinterface

interface bwcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] low_half;
  logic [15:0] high_half;
  logic [15:0] crc_value;

  modport source (output valid, output low_half, output high_half, output crc_value,
                  input ready);
  modport sink (input valid, input low_half, input high_half, input crc_value,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/boot_image_word_cipher_crc.sv -----
// Top level: input register, cipher and CRC step, result register and configuration.
// A beat passes the input register and then the result register before it is offered.
// Throughput is one beat per cycle unless the output stalls; the constant multiply and
// the CRC fold are combinational, in the cycle the seed and CRC registers update.
// Synchronous active-low reset sets the seed to FFFF00C1, the CRC to FFF8, both
// configuration bytes to zero and empties both register stages.
`default_nettype none
module boot_image_word_cipher_crc (
  input  wire logic       clk,
  input  wire logic       rst_n,
  bwcc_in_if.sink         in_beat,
  bwcc_out_if.source      out_beat,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import bwcc_pkg::*;

  logic        s1_valid_r;
  logic [1:0]  s1_opcode_r;
  logic [31:0] s1_word_r;
  logic [17:0] s1_offset_r;
  logic        s1_adv;
  logic        in_ready;

  logic        out_valid_r;
  logic [31:0] out_enc_r;
  logic [15:0] out_crc_r;

  logic [7:0]  seed_byte_r;
  logic [7:0]  client_byte_r;

  ctl_t        ctl;
  logic [15:0] crc_step;
  logic [31:0] enc_word;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_beat.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_beat.ready = in_ready;

  assign ctl.fire    = s1_adv;
  assign ctl.restart = s1_opcode_r == OP_RESTART;
  assign ctl.encode  = s1_opcode_r == OP_ENCODE;
  assign ctl.finish  = s1_opcode_r == OP_FINISH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_byte_r   <= '0;
      client_byte_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEED_BYTE:   seed_byte_r   <= cfg_wdata;
        CFG_CLIENT_BYTE: client_byte_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_beat.valid) begin
      s1_opcode_r <= in_beat.opcode;
      s1_word_r   <= in_beat.data_word;
      s1_offset_r <= in_beat.byte_offset;
    end
  end

  bwcc_crc u_crc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .data_word   (s1_word_r),
    .seed_byte   (seed_byte_r),
    .client_byte (client_byte_r),
    .crc_step    (crc_step)
  );

  bwcc_cipher u_cipher (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .data_word   (s1_word_r),
    .byte_offset (s1_offset_r),
    .seed_byte   (seed_byte_r),
    .enc_word    (enc_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_enc_r <= enc_word;
      out_crc_r <= crc_step;
    end
  end

  assign out_beat.valid     = out_valid_r;
  assign out_beat.low_half  = out_enc_r[15:0];
  assign out_beat.high_half = out_enc_r[31:16];
  assign out_beat.crc_value = out_crc_r;

`ifndef ASSERT_OFF
  a_restart_crc: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && ctl.restart |=> out_valid_r && out_crc_r == CRC_INIT)
    else $error("restart beat did not report the initial CRC");

  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !ctl.encode |=> out_enc_r == 32'd0)
    else $error("non-encode beat carried a non-zero cipher word");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_ready)
    else $error("input taken while the execute stage was blocked");

  a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("executed beat did not reach the result register");
`endif

endmodule
`default_nettype wire

// ----- rtl/bwcc_crc.sv -----
// Running CRC register with its combinational 32-bit fold.
`default_nettype none
module bwcc_crc (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire bwcc_pkg::ctl_t ctl,
  input  wire logic [31:0]  data_word,
  input  wire logic [7:0]   seed_byte,
  input  wire logic [7:0]   client_byte,
  output logic      [15:0]  crc_step
);
  import bwcc_pkg::*;

  logic [15:0] running_crc_r;
  logic [31:0] trailer;

  assign trailer = {TRAILER_HIGH, client_byte, seed_byte + SEED_BIAS};

  always_comb begin
    crc_step = running_crc_r;
    if (ctl.restart) begin
      crc_step = CRC_INIT;
    end else if (ctl.encode) begin
      crc_step = crc_fold32(running_crc_r, data_word);
    end else if (ctl.finish) begin
      crc_step = crc_fold32(running_crc_r, trailer);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= CRC_INIT;
    end else if (ctl.fire) begin
      running_crc_r <= crc_step;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bwcc_cipher.sv -----
// Seed generator and word encryption.
`default_nettype none
module bwcc_cipher (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bwcc_pkg::ctl_t ctl,
  input  wire logic [31:0]    data_word,
  input  wire logic [17:0]    byte_offset,
  input  wire logic [7:0]     seed_byte,
  output logic      [31:0]    enc_word
);
  import bwcc_pkg::*;

  logic [31:0] cipher_seed_r;
  logic [31:0] cipher_seed_nxt;
  logic [31:0] seed_adv;
  logic [31:0] addr_mask;

  assign seed_adv  = cipher_seed_r * SEED_MULT + 32'd1;
  assign addr_mask = (32'd0 - ({14'd0, byte_offset} + LOAD_BASE)) ^ ADDR_KEY;

  always_comb begin
    cipher_seed_nxt = cipher_seed_r;
    enc_word        = '0;
    if (ctl.restart) begin
      cipher_seed_nxt = SEED_INIT | {16'd0, seed_byte, 8'd0};
    end else if (ctl.encode) begin
      cipher_seed_nxt = seed_adv;
      enc_word        = seed_adv ^ data_word ^ addr_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_seed_r <= SEED_INIT;
    end else if (ctl.fire) begin
      cipher_seed_r <= cipher_seed_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_boot_image_word_cipher_crc.sv -----
// Self-checking testbench for the boot image word cipher and CRC block.
`timescale 1ns / 100ps
module tb_boot_image_word_cipher_crc;
  import bwcc_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int CHUNK_COUNT = 6;
  localparam int CHUNK_BEATS = 165;
  localparam int DIRECTED_COUNT = 15;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] low_half;
    logic [15:0] high_half;
    logic [15:0] crc_value;
  } cipher_result_t;

  typedef struct packed {
    logic [1:0]     op;
    logic [31:0]    word;
    logic [17:0]    offset;
    logic           typed;
    cipher_result_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_index;
  logic [7:0] cfg_wdata;

  bwcc_in_if in_ch ();
  bwcc_out_if out_ch ();

  boot_image_word_cipher_crc uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_ch),
    .out_beat  (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [31:0] seed_now;
  logic [15:0] crc_now;
  logic [7:0] seed_byte_now;
  logic [7:0] client_byte_now;
  cipher_result_t expected_results[$];
  int fail_count;
  int src_idle_pct;
  int sink_idle_pct;

  // Typed rows hold results that follow directly from a restart or from reset.
  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{OP_UNUSED,  32'h0000_0000, 18'h00000, 1'b1, '{16'h0, 16'h0, CRC_INIT}},
    '{OP_ENCODE,  32'h0000_0000, 18'h00000, 1'b0, '0},
    '{OP_ENCODE,  32'hFFFF_FFFF, 18'h3FFFF, 1'b0, '0},
    '{OP_ENCODE,  32'h1234_5678, 18'h3FFFC, 1'b0, '0},
    '{OP_ENCODE,  32'hA5A5_A5A5, 18'h00001, 1'b0, '0},
    '{OP_FINISH,  32'h0000_0000, 18'h00000, 1'b0, '0},
    '{OP_UNUSED,  32'hFFFF_FFFF, 18'h3FFFF, 1'b0, '0},
    '{OP_RESTART, 32'h0000_0000, 18'h00000, 1'b1, '{16'h0, 16'h0, CRC_INIT}},
    '{OP_FINISH,  32'h0000_0000, 18'h00000, 1'b0, '0},
    '{OP_RESTART, 32'h0000_0000, 18'h00000, 1'b1, '{16'h0, 16'h0, CRC_INIT}},
    '{OP_ENCODE,  32'h8000_0000, 18'h00002, 1'b0, '0},
    '{OP_ENCODE,  32'h0000_0001, 18'h20000, 1'b0, '0},
    '{OP_RESTART, 32'hFFFF_FFFF, 18'h3FFFF, 1'b1, '{16'h0, 16'h0, CRC_INIT}},
    '{OP_FINISH,  32'hFFFF_FFFF, 18'h3FFFF, 1'b0, '0},
    '{OP_UNUSED,  32'h5A5A_0F0F, 18'h15555, 1'b0, '0}
  };

  logic [7:0] chunk_seed_byte [CHUNK_COUNT] = '{8'hFF, 8'h00, 8'hF1, 8'h5A, 8'h80, 8'h00};
  logic [7:0] chunk_client_byte [CHUNK_COUNT] = '{8'hFF, 8'hFF, 8'h00, 8'hA5, 8'h01, 8'h00};

  function automatic logic [15:0] fold_crc(logic [15:0] crc_in, logic [31:0] word_in);
    logic [15:0] crc;
    logic [31:0] word;
    logic        hit;
    crc = crc_in;
    word = word_in;
    for (int i = 0; i < 32; i++) begin
      hit = crc[0] ^ word[0];
      crc = crc >> 1;
      word = word >> 1;
      if (hit) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic cipher_result_t cipher_step(logic [1:0] op, logic [31:0] word,
                                                 logic [17:0] offset);
    cipher_result_t result;
    logic [31:0] enc;
    logic [31:0] load_addr;
    enc = '0;
    case (op)
      OP_RESTART: begin
        seed_now = SEED_INIT | {16'h0000, seed_byte_now, 8'h00};
        crc_now = CRC_INIT;
      end
      OP_ENCODE: begin
        crc_now = fold_crc(crc_now, word);
        seed_now = seed_now * SEED_MULT + 32'd1;
        load_addr = {14'd0, offset} + LOAD_BASE;
        enc = seed_now ^ word ^ ((32'd0 - load_addr) ^ ADDR_KEY);
      end
      OP_FINISH: begin
        crc_now = fold_crc(crc_now, {TRAILER_HIGH, client_byte_now, seed_byte_now + SEED_BIAS});
      end
      default: begin
      end
    endcase
    result.low_half = enc[15:0];
    result.high_half = enc[31:16];
    result.crc_value = crc_now;
    return result;
  endfunction

  task automatic push_beat(input logic [1:0] op, input logic [31:0] word,
                           input logic [17:0] offset, input logic typed,
                           input cipher_result_t typed_result);
    cipher_result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.data_word <= word;
    in_ch.byte_offset <= offset;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predicted = cipher_step(op, word, offset);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic push_predicted(input logic [1:0] op, input logic [31:0] word,
                                input logic [17:0] offset);
    push_beat(op, word, offset, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_config(input logic [7:0] seed_value, input logic [7:0] client_value);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SEED_BYTE;
    cfg_wdata <= seed_value;
    @(posedge clk);
    seed_byte_now = seed_value;
    cfg_index <= CFG_CLIENT_BYTE;
    cfg_wdata <= client_value;
    @(posedge clk);
    client_byte_now = client_value;
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly whole images: restart, a run of encoded words at rising offsets, then finish.
  task automatic run_image_chunk(input int beat_target);
    int sent;
    int run_len;
    logic [17:0] offset;
    logic [31:0] word;
    sent = 0;
    while (sent < beat_target) begin
      if ($urandom_range(0, 99) < 85) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 24);
        offset = ($urandom_range(0, 3) == 0) ? 18'd0 : (18'($urandom) & 18'h3FFFC);
        push_predicted(OP_RESTART, $urandom, 18'($urandom));
        for (int i = 0; i < run_len; i++) begin
          case ($urandom_range(0, 9))
            0: word = 32'h0000_0000;
            1: word = 32'hFFFF_FFFF;
            default: word = $urandom;
          endcase
          push_predicted(OP_ENCODE, word, offset);
          offset = offset + 18'd4;
        end
        push_predicted(OP_FINISH, $urandom, 18'($urandom));
        sent = sent + run_len + 2;
      end else begin
        push_predicted(2'($urandom_range(0, 3)), $urandom, 18'($urandom));
        sent = sent + 1;
      end
    end
  endtask

  task automatic report_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  initial begin
    clk = 1'b0;
  end

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h %h %h", $time,
                 out_ch.low_half, out_ch.high_half, out_ch.crc_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        report_field("low_half", want.low_half, out_ch.low_half);
        report_field("high_half", want.high_half, out_ch.high_half);
        report_field("crc_value", want.crc_value, out_ch.crc_value);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("boot_image_word_cipher_crc regression: fail");
    $finish;
  end

  initial begin
    fail_count = 0;
    src_idle_pct = 34;
    sink_idle_pct = 70;
    seed_now = SEED_INIT;
    crc_now = CRC_INIT;
    seed_byte_now = 8'h00;
    client_byte_now = 8'h00;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_SEED_BYTE;
    cfg_wdata <= 8'h00;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_RESTART;
    in_ch.data_word <= 32'h0;
    in_ch.byte_offset <= 18'h0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      push_beat(directed_rows[i].op, directed_rows[i].word, directed_rows[i].offset,
                directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
      src_idle_pct = (chunk < 2) ? 34 : (chunk < 4) ? 70 : 0;
      sink_idle_pct = (chunk < 2) ? 70 : (chunk < 4) ? 34 : 0;
      if (chunk == CHUNK_COUNT - 1) begin
        write_config(8'($urandom), 8'($urandom));
      end else begin
        write_config(chunk_seed_byte[chunk], chunk_client_byte[chunk]);
      end
      run_image_chunk(CHUNK_BEATS);
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("boot_image_word_cipher_crc regression: pass");
    end else begin
      $display("boot_image_word_cipher_crc regression: fail");
    end
    $finish;
  end

endmodule
